[rtl/swp_pkg.sv]
// Shared constants, command and status types, and the percentile rank table.
package swp_pkg;

    localparam int SAMPLE_W     = 32;
    localparam int HELD_W       = 6;
    localparam int WINDOW_DEPTH = 32;
    localparam int PTR_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);

    localparam int PCT_RANK  = 95;
    localparam int PCT_ROUND = 99;
    localparam int PCT_SCALE = 100;

    typedef logic [PTR_W-1:0] rank_lut_t [0:WINDOW_DEPTH];

    // Nearest-rank index into the sorted window for every possible fill level.
    function automatic rank_lut_t build_rank_lut();
        rank_lut_t lut;
        int        k;
        for (int n = 0; n <= WINDOW_DEPTH; n++) begin
            if (n == 0) begin
                k = 0;
            end
            else begin
                k = (n * PCT_RANK + PCT_ROUND) / PCT_SCALE;
                k = (k > 0) ? k - 1 : 0;
                if (k >= n) begin
                    k = n - 1;
                end
            end
            lut[n] = PTR_W'(k);
        end
        return lut;
    endfunction

    localparam rank_lut_t RANK_LUT = build_rank_lut();

    typedef struct packed {
        logic take;  // latch the input beat and start the ring read
        logic del;   // remove the oldest sample from the sorted bank
        logic ins;   // insert the new sample and write it to the ring
        logic pick;  // look up the rank index for the current fill level
        logic load;  // load the result register
    } swp_cmd_t;

    typedef struct packed {
        logic clearing;
        logic full;
    } swp_status_t;

endpackage

[rtl/swp_in_if.sv]
// Input channel: one sample beat per handshake.
interface swp_in_if
    import swp_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                action;
    logic [SAMPLE_W-1:0] sample_value;

    modport source (output valid, output action, output sample_value, input ready);
    modport sink   (input valid, input action, input sample_value, output ready);
endinterface

[rtl/swp_out_if.sv]
// Output channel: one percentile result beat per handshake.
interface swp_out_if
    import swp_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] p95_value;
    logic [HELD_W-1:0]   samples_held;

    modport source (output valid, output p95_value, output samples_held, input ready);
    modport sink   (input valid, input p95_value, input samples_held, output ready);
endinterface

[rtl/swp_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module swp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                       clk,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic                                       rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

[rtl/swp_ctrl.sv]
// Percentile sequencer: add beats run delete, insert, pick; clears skip to pick.
module swp_ctrl
    import swp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  swp_status_t status,
    output swp_cmd_t    cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEL  = 3'd1;
    localparam logic [2:0] S_INS  = 3'd2;
    localparam logic [2:0] S_PICK = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_DEL;
                end
            end
            S_DEL:
            begin
                if (status.clearing)
                begin
                    state_next = S_PICK;
                end
                else
                begin
                    cmd.del    = status.full;
                    state_next = S_INS;
                end
            end
            S_INS:
            begin
                cmd.ins    = 1'b1;
                state_next = S_PICK;
            end
            S_PICK:
            begin
                cmd.pick   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A new beat is never taken while the previous one is still being worked on.
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while the sequencer was busy");

    // The result register is only ever filled from the output state.
    a_load_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_OUT))
        else $error("result appeared outside the output state");

    // A finished result waits in the output state while the register is occupied.
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_valid_reg && !out_ready) |=> (state_reg == S_OUT))
        else $error("result overwritten before it was taken");
endmodule

[rtl/swp_dp.sv]
// Datapath: sample ring, sorted register bank, fill count and result register.
module swp_dp
    import swp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  swp_cmd_t            cmd,
    output swp_status_t         status,
    input  logic                action,
    input  logic [SAMPLE_W-1:0] sample_value,
    output logic [SAMPLE_W-1:0] p95_value,
    output logic [HELD_W-1:0]   samples_held
);
    logic                action_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [PTR_W-1:0]    wp_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [PTR_W-1:0]    idx_reg;
    logic [SAMPLE_W-1:0] sorted_reg [WINDOW_DEPTH];
    logic [SAMPLE_W-1:0] del_next   [WINDOW_DEPTH];
    logic [SAMPLE_W-1:0] ins_next   [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] ge_old;
    logic [WINDOW_DEPTH-1:0] gt_new;
    logic [SAMPLE_W-1:0] oldest;
    logic [SAMPLE_W-1:0] p95_reg;
    logic [HELD_W-1:0]   held_reg;
    logic [PTR_W-1:0]    wp_next;
    logic                ring_wr;

    assign ring_wr = cmd.ins && !action_reg;
    assign wp_next = (wp_reg == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : wp_reg + 1'b1;

    // The oldest sample sits at the write pointer once the window is full.
    swp_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ring_wr),
        .wr_addr (wp_reg),
        .wr_data (sample_reg),
        .rd_en   (cmd.take),
        .rd_addr (wp_reg),
        .rd_data (oldest)
    );

    // The bank is kept in ascending order. Removing a value shifts down every
    // entry at or above it; inserting shifts up every entry above the new one.
    always_comb
    begin
        for (int i = 0; i < WINDOW_DEPTH; i++)
        begin
            ge_old[i] = (sorted_reg[i] >= oldest);
            gt_new[i] = (CNT_W'(i) >= count_reg) || (sorted_reg[i] > sample_reg);
        end
        for (int i = 0; i < WINDOW_DEPTH; i++)
        begin
            if (i < WINDOW_DEPTH - 1 && ge_old[i])
            begin
                del_next[i] = sorted_reg[(i < WINDOW_DEPTH - 1) ? i + 1 : i];
            end
            else
            begin
                del_next[i] = sorted_reg[i];
            end
            if (i > 0 && gt_new[(i > 0) ? i - 1 : 0])
            begin
                ins_next[i] = sorted_reg[(i > 0) ? i - 1 : 0];
            end
            else if (gt_new[i])
            begin
                ins_next[i] = sample_reg;
            end
            else
            begin
                ins_next[i] = sorted_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            sample_reg <= sample_value;
        end
        if (cmd.del)
        begin
            sorted_reg <= del_next;
        end
        else if (ring_wr)
        begin
            sorted_reg <= ins_next;
        end
        if (cmd.pick)
        begin
            idx_reg <= RANK_LUT[count_reg];
        end
        if (cmd.load)
        begin
            p95_reg  <= (count_reg == '0) ? '0 : sorted_reg[idx_reg];
            held_reg <= HELD_W'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            action_reg <= 1'b0;
            wp_reg     <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (cmd.take)
            begin
                action_reg <= action;
            end
            if (cmd.take && action)
            begin
                wp_reg    <= '0;
                count_reg <= '0;
            end
            else if (cmd.del)
            begin
                count_reg <= count_reg - 1'b1;
            end
            else if (ring_wr)
            begin
                wp_reg    <= wp_next;
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    assign status.clearing = action_reg;
    assign status.full     = (count_reg == CNT_W'(WINDOW_DEPTH));
    assign p95_value       = p95_reg;
    assign samples_held    = held_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(WINDOW_DEPTH))
        else $error("fill count beyond the window depth");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take && action) |=> (count_reg == '0 && wp_reg == '0))
        else $error("clear did not empty the window");

    a_delete_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.del |-> (status.full && !status.clearing))
        else $error("oldest sample removed from a window that is not full");
endmodule

[rtl/sliding_window_percentile_unit.sv]
// Sliding-window nearest-rank 95th percentile over the most recent latency samples.
// Each add beat is taken, then steps through delete-oldest, insert-new, rank lookup and
// result load; a clear beat skips the delete and insert. A new beat is taken only once
// the previous one has loaded its result.
// Reset clears the fill count, write pointer and sequencer; the window starts empty and
// the ring needs no clearing pass.
module sliding_window_percentile_unit
    import swp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    swp_in_if.sink    samples,
    swp_out_if.source results
);
    // The sequencer and the datapath talk only through the command and status
    // structs. Each input beat is taken in the idle state; the oldest ring entry
    // is fetched at the same time so that, once the window is full, it can be
    // removed from the sorted bank before the new sample goes in.
    swp_cmd_t    cmd;
    swp_status_t status;

    swp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // The result register lets the next beat be taken while a finished
    // result is still waiting to be read downstream.
    swp_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .action       (samples.action),
        .sample_value (samples.sample_value),
        .p95_value    (results.p95_value),
        .samples_held (results.samples_held)
    );
endmodule

[sim/testbench.sv]
// Self-checking testbench for the sliding-window 95th percentile unit.
`timescale 1ns / 1ps

module testbench
    import swp_pkg::*;
();

    // Encoding of the action field on the input channel.
    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    localparam int RANDOM_BEATS = 1250;
    localparam int PHASE_LEN    = 125;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_IDLE     = 13;
    localparam int REPORT_CAP   = 40;

    // One expected result beat.
    typedef struct {
        logic [SAMPLE_W-1:0] p95;
        logic [HELD_W-1:0]   held;
    } p95_result_t;

    // Keeps a private copy of the window, works out the percentile for every
    // accepted beat and matches the results against it in order.
    class p95_scoreboard;
        logic [SAMPLE_W-1:0] window_ring [WINDOW_DEPTH];
        logic [PTR_W-1:0]    next_slot;
        logic [CNT_W-1:0]    fill;
        p95_result_t         awaited [$];
        int                  mismatches;

        function new();
            next_slot  = '0;
            fill       = '0;
            mismatches = 0;
        endfunction

        task report_mismatch(input string what);
            mismatches++;
            if (mismatches <= REPORT_CAP)
                $display("%0t ns: mismatch: %s", $realtime, what);
        endtask

        // Updates the window for one accepted input beat and queues the result it causes.
        function void note_beat(input logic act, input logic [SAMPLE_W-1:0] val);
            logic [SAMPLE_W-1:0] ordered [WINDOW_DEPTH];
            logic [SAMPLE_W-1:0] key;
            p95_result_t         want;
            int                  n;
            int                  j;
            int                  rank;

            if (act == ACT_CLEAR)
            begin
                next_slot = '0;
                fill      = '0;
            end
            else
            begin
                window_ring[next_slot] = val;
                next_slot = (next_slot == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : next_slot + 1'b1;
                if (fill < CNT_W'(WINDOW_DEPTH))
                    fill = fill + 1'b1;
            end

            n = int'(fill);
            want.held = HELD_W'(n);
            want.p95  = '0;
            if (n > 0)
            begin
                // Only slots below the fill level have been written since the last clear.
                for (int i = 0; i < n; i++)
                    ordered[i] = window_ring[i];
                for (int i = 1; i < n; i++)
                begin
                    key = ordered[i];
                    j   = i;
                    while (j > 0 && ordered[j-1] > key)
                    begin
                        ordered[j] = ordered[j-1];
                        j--;
                    end
                    ordered[j] = key;
                end
                rank = (n * PCT_RANK + PCT_ROUND) / PCT_SCALE;
                if (rank > 0)
                    rank--;
                if (rank >= n)
                    rank = n - 1;
                want.p95 = ordered[rank];
            end
            awaited.push_back(want);
        endfunction

        task check_result(input logic [SAMPLE_W-1:0] p95, input logic [HELD_W-1:0] held);
            p95_result_t want;
            if (awaited.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result p95=%0d held=%0d", p95, held));
            end
            else
            begin
                want = awaited.pop_front();
                if (p95 !== want.p95)
                    report_mismatch($sformatf("p95_value %0d, expected %0d", p95, want.p95));
                if (held !== want.held)
                    report_mismatch($sformatf("samples_held %0d, expected %0d",
                                              held, want.held));
            end
        endtask

        function int pending();
            return awaited.size();
        endfunction

        task flush_leftovers();
            while (awaited.size() > 0)
            begin
                void'(awaited.pop_front());
                report_mismatch("expected result never arrived");
            end
        endtask
    endclass

    logic clk;
    logic rst_n;

    swp_in_if  samples_if ();
    swp_out_if results_if ();

    sliding_window_percentile_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_if),
        .results (results_if)
    );

    p95_scoreboard sb = new();

    // Upper bounds of the idle draws for each side; zero gives a stretch with no idling.
    int  send_idle_max = MAX_IDLE;
    int  recv_idle_max = MAX_IDLE;
    // Raised once by the stimulus to make the receiver hold off for a long stretch.
    bit  hold_request  = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Offers one beat after a random gap and waits until the block takes it.
    // The valid line is only lowered when a gap follows, so a back-to-back beat
    // keeps valid high across the acceptance edge.
    task drive_beat(input logic act, input logic [SAMPLE_W-1:0] val);
        int gap;
        gap = (send_idle_max > 0) ? $urandom_range(0, send_idle_max) : 0;
        if (gap > 0)
        begin
            samples_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        samples_if.valid        <= 1'b1;
        samples_if.action       <= act;
        samples_if.sample_value <= val;
        do
            @(posedge clk);
        while (!samples_if.ready);
        sb.note_beat(act, val);
    endtask

    // Sample values are skewed towards duplicates and the ends of the range,
    // since ties and extremes are where a sorting network tends to go wrong.
    function automatic logic [SAMPLE_W-1:0] draw_sample();
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom_range(0, 15);
            3:       return '1 - SAMPLE_W'($urandom_range(0, 15));
            4:       return ($urandom_range(0, 1) != 0) ? '1 : '0;
            5:       return SAMPLE_W'(1) << $urandom_range(0, SAMPLE_W - 1);
            default: return $urandom();
        endcase
    endfunction

    // Receiver: random stalls per beat, plus one long hold-off on request so that
    // the block backs up and stops taking input.
    initial
    begin
        int stall;
        bit held_off;
        held_off = 1'b0;
        results_if.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_request && !held_off)
            begin
                results_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                held_off = 1'b1;
            end
            stall = (recv_idle_max > 0) ? $urandom_range(0, recv_idle_max) : 0;
            if (stall > 0)
            begin
                results_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            results_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(results_if.valid && results_if.ready));
            sb.check_result(results_if.p95_value, results_if.samples_held);
        end
    end

    // Stimulus: a short directed opening, then random traffic in phases with
    // changing idle behaviour on both sides.
    initial
    begin
        logic act;
        rst_n                   <= 1'b0;
        samples_if.valid        <= 1'b0;
        samples_if.action       <= ACT_ADD;
        samples_if.sample_value <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Clear on an empty window, then the smallest and largest samples,
        // ties, and a clear on a partly filled window.
        drive_beat(ACT_CLEAR, '1);
        drive_beat(ACT_ADD,   '0);
        drive_beat(ACT_ADD,   '1);
        drive_beat(ACT_ADD,   32'd1);
        drive_beat(ACT_ADD,   '1);
        drive_beat(ACT_ADD,   '0);
        drive_beat(ACT_CLEAR, 32'h5555_AAAA);
        drive_beat(ACT_CLEAR, '0);
        drive_beat(ACT_ADD,   32'h8000_0000);
        drive_beat(ACT_ADD,   32'h7FFF_FFFF);
        for (int i = 0; i < 12; i++)
            drive_beat(ACT_ADD, 32'd1000 - 32'(i * 7));
        drive_beat(ACT_ADD,   32'hAAAA_5555);
        drive_beat(ACT_CLEAR, '0);

        // Clears are rare, so the window often fills and wraps between them.
        for (int i = 0; i < RANDOM_BEATS; i++)
        begin
            if (i % PHASE_LEN == 0)
            begin
                send_idle_max = ((i / PHASE_LEN) % 3 == 1) ? 0 : MAX_IDLE;
                recv_idle_max = ((i / PHASE_LEN) % 4 == 2) ? 0 : MAX_IDLE;
                // Midway, the sender runs flat out while the receiver holds off.
                if (i == 5 * PHASE_LEN)
                begin
                    send_idle_max = 0;
                    hold_request  = 1'b1;
                end
            end
            act = ($urandom_range(0, 59) == 0) ? ACT_CLEAR : ACT_ADD;
            drive_beat(act, draw_sample());
        end
        samples_if.valid <= 1'b0;

        while (sb.pending() > 0)
            @(posedge clk);
        // Allow for a stray result beyond the add latency.
        repeat (16) @(posedge clk);
        sb.flush_leftovers();

        if (sb.mismatches == 0)
            $display("** sliding_window_percentile_unit: PASSED **");
        else
            $display("** sliding_window_percentile_unit: FAILED **");
        $finish;
    end

    // Watchdog: several times the slowest legal run, including the long hold-off.
    initial
    begin
        #3_000_000;
        $display("** sliding_window_percentile_unit: FAILED **");
        $finish;
    end

endmodule
